// ----- sv/xxtea_block_cipher_macros.svh -----
// assertion macros for the xxtea block cipher
// expects clk and rst_n in the scope where the macros are used
`ifndef XXTEA_BLOCK_CIPHER_MACROS_SVH
`define XXTEA_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication
`define XXT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XXT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/xxtea_pkg.sv -----
// shared constants, state codes and functions for the xxtea block cipher
// no dependencies
`default_nettype none

package xxtea_pkg;

  localparam int MAX_WORDS = 64;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS = 3'd5;

  // sequencer states
  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_INIT_A = 3'd1;
  localparam logic [2:0] ST_INIT_B = 3'd2;
  localparam logic [2:0] ST_INIT_C = 3'd3;
  localparam logic [2:0] ST_RD     = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // zero counts as one, anything above the store depth saturates
  function automatic logic [CNT_W-1:0] eff_words(input logic [6:0] bw);
    logic [CNT_W-1:0] n;
    if (bw == 7'd0) begin
      n = CNT_W'(1);
    end else if (bw > 7'(MAX_WORDS)) begin
      n = CNT_W'(MAX_WORDS);
    end else begin
      n = CNT_W'(bw);
    end
    return n;
  endfunction

  // 6 + 52/n full rounds
  function automatic logic [5:0] round_count(input logic [CNT_W-1:0] n);
    logic [5:0] q;
    case (7'(n)) inside
      7'd0, 7'd1: q = 6'd52;
      7'd2:       q = 6'd26;
      7'd3:       q = 6'd17;
      7'd4:       q = 6'd13;
      7'd5:       q = 6'd10;
      7'd6:       q = 6'd8;
      7'd7:       q = 6'd7;
      7'd8:       q = 6'd6;
      [7'd9:7'd10]:  q = 6'd5;
      [7'd11:7'd13]: q = 6'd4;
      [7'd14:7'd17]: q = 6'd3;
      [7'd18:7'd26]: q = 6'd2;
      [7'd27:7'd52]: q = 6'd1;
      default:    q = 6'd0;
    endcase
    return 6'(q + 6'd6);
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] y,
                                            input logic [WORD_W-1:0] z,
                                            input logic [WORD_W-1:0] sum,
                                            input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] rhs;
    lhs = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    rhs = (sum ^ y) + (k ^ z);
    return lhs ^ rhs;
  endfunction

endpackage

`default_nettype wire

// ----- sv/xxtea_block_cipher.sv -----
// xxtea block cipher: word store in one ram, one word update per read-modify-write
// depends on xxtea_pkg, xxtea_ram and xxtea_block_cipher_macros.svh
//
//  channel | ports                                   | transaction
//  --------+-----------------------------------------+----------------------------
//  input   | start, busy, in_data_word               | start high while busy low
//  result  | out_valid, out_result_word, out_last_word| out_valid high, one cycle
//  config  | cfg_we, cfg_index, cfg_data             | cfg_we high
//
// words load one per cycle while busy is low; busy rises after the last word of
// a block of n; the single ram read port gives each word update a read state and
// an update state (ram read, then update and write back); setup states INIT_A,
// INIT_B, INIT_C, then (6 + 52/n) rounds of n word updates, then n results, one
// per clock, which the receiver cannot stall; a one-word block skips rounds
// synchronous active-low reset; store contents are not cleared, no clearing pass
`default_nettype none

module xxtea_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_data_word,
  output logic             out_valid,
  output logic [31:0]      out_result_word,
  output logic             out_last_word,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

`include "xxtea_block_cipher_macros.svh"

  localparam int AW = xxtea_pkg::ADDR_W;
  localparam int CW = xxtea_pkg::CNT_W;
  localparam int WW = xxtea_pkg::WORD_W;

  // configuration registers
  logic [WW-1:0] key_r [4];
  logic          decrypt_r;
  logic [6:0]    block_words_r;

  // sequencer
  logic [2:0]    state_r;
  logic [2:0]    state_nxt;
  logic [CW-1:0] loaded_cnt_r;
  logic [CW-1:0] n_r;
  logic          dec_r;
  logic [5:0]    rounds_r;
  logic [AW-1:0] pos_r;
  logic [WW-1:0] sum_r;
  logic [WW-1:0] x_r;   // old value of the word being updated
  logic [WW-1:0] a_r;   // last updated word, z when encrypting, y when decrypting
  logic [WW-1:0] f_r;   // first word updated in the current round
  logic          out_valid_r;
  logic          out_last_r;

  logic          accept;
  logic [CW-1:0] n_eff;
  logic          load_done;
  logic [CW-1:0] n_m1;
  logic          first_step;
  logic          last_step;
  logic [1:0]    key_idx;
  logic [WW-1:0] nbr;
  logic [WW-1:0] mix_v;
  logic [WW-1:0] upd;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  xxtea_ram #(
    .WIDTH(WW),
    .DEPTH(xxtea_pkg::MAX_WORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign busy      = (state_r != xxtea_pkg::ST_LOAD);
  assign accept    = start && !busy;
  assign n_eff     = xxtea_pkg::eff_words(block_words_r);
  assign load_done = (loaded_cnt_r + CW'(1)) >= n_eff;
  assign n_m1      = n_r - CW'(1);

  assign first_step = dec_r ? (pos_r == n_m1[AW-1:0]) : (pos_r == '0);
  assign last_step  = dec_r ? (pos_r == '0) : (pos_r == n_m1[AW-1:0]);

  assign key_idx = pos_r[1:0] ^ sum_r[3:2];
  // the step that closes a round uses the word updated first in that round
  assign nbr     = last_step ? f_r : ram_rdata;
  assign mix_v   = dec_r ? xxtea_pkg::mix(a_r, nbr, sum_r, key_r[key_idx])
                         : xxtea_pkg::mix(nbr, a_r, sum_r, key_r[key_idx]);
  assign upd     = dec_r ? (x_r - mix_v) : (x_r + mix_v);

  // store port selection; loading and updating never overlap
  assign ram_we    = accept || (state_r == xxtea_pkg::ST_UPD);
  assign ram_waddr = accept ? loaded_cnt_r[AW-1:0] : pos_r;
  assign ram_wdata = accept ? in_data_word : upd;

  always_comb begin
    case (state_r)
      xxtea_pkg::ST_INIT_A: ram_raddr = dec_r ? n_m1[AW-1:0] : '0;
      xxtea_pkg::ST_INIT_B: ram_raddr = dec_r ? '0 : n_m1[AW-1:0];
      xxtea_pkg::ST_RD:     ram_raddr = dec_r ? (pos_r - AW'(1)) : (pos_r + AW'(1));
      default:              ram_raddr = pos_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xxtea_pkg::ST_LOAD: begin
        if (accept && load_done) begin
          state_nxt = (n_eff == CW'(1)) ? xxtea_pkg::ST_OUT : xxtea_pkg::ST_INIT_A;
        end
      end
      xxtea_pkg::ST_INIT_A: state_nxt = xxtea_pkg::ST_INIT_B;
      xxtea_pkg::ST_INIT_B: state_nxt = xxtea_pkg::ST_INIT_C;
      xxtea_pkg::ST_INIT_C: state_nxt = xxtea_pkg::ST_RD;
      xxtea_pkg::ST_RD:     state_nxt = xxtea_pkg::ST_UPD;
      xxtea_pkg::ST_UPD: begin
        if (last_step && rounds_r == 6'd1) begin
          state_nxt = xxtea_pkg::ST_OUT;
        end else begin
          state_nxt = xxtea_pkg::ST_RD;
        end
      end
      xxtea_pkg::ST_OUT: begin
        if ({1'b0, pos_r} == n_m1) begin
          state_nxt = xxtea_pkg::ST_LOAD;
        end
      end
      default: state_nxt = xxtea_pkg::ST_LOAD;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]      <= '0;
      key_r[1]      <= '0;
      key_r[2]      <= '0;
      key_r[3]      <= '0;
      decrypt_r     <= 1'b0;
      block_words_r <= 7'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        xxtea_pkg::CFG_KEY0:        key_r[0]      <= cfg_data;
        xxtea_pkg::CFG_KEY1:        key_r[1]      <= cfg_data;
        xxtea_pkg::CFG_KEY2:        key_r[2]      <= cfg_data;
        xxtea_pkg::CFG_KEY3:        key_r[3]      <= cfg_data;
        xxtea_pkg::CFG_DECRYPT:     decrypt_r     <= cfg_data[0];
        xxtea_pkg::CFG_BLOCK_WORDS: block_words_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= xxtea_pkg::ST_LOAD;
      loaded_cnt_r <= '0;
      n_r          <= CW'(1);
      dec_r        <= 1'b0;
      rounds_r     <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      case (state_r)
        xxtea_pkg::ST_LOAD: begin
          if (accept) begin
            if (load_done) begin
              loaded_cnt_r <= '0;
              n_r          <= n_eff;
              dec_r        <= decrypt_r;
              rounds_r     <= xxtea_pkg::round_count(n_eff);
              pos_r        <= '0;
            end else begin
              loaded_cnt_r <= loaded_cnt_r + CW'(1);
            end
          end
        end
        xxtea_pkg::ST_INIT_C: begin
          pos_r <= dec_r ? n_m1[AW-1:0] : '0;
        end
        xxtea_pkg::ST_UPD: begin
          if (last_step) begin
            rounds_r <= rounds_r - 6'd1;
            if (rounds_r == 6'd1) begin
              pos_r <= '0;
            end else begin
              pos_r <= dec_r ? n_m1[AW-1:0] : '0;
            end
          end else begin
            pos_r <= dec_r ? (pos_r - AW'(1)) : (pos_r + AW'(1));
          end
        end
        xxtea_pkg::ST_OUT: begin
          out_valid_r <= 1'b1;
          out_last_r  <= ({1'b0, pos_r} == n_m1);
          pos_r       <= pos_r + AW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      xxtea_pkg::ST_INIT_A: begin
        sum_r <= dec_r ? WW'(xxtea_pkg::TEA_DELTA * {26'd0, rounds_r})
                       : xxtea_pkg::TEA_DELTA;
      end
      xxtea_pkg::ST_INIT_B: x_r <= ram_rdata;
      xxtea_pkg::ST_INIT_C: a_r <= ram_rdata;
      xxtea_pkg::ST_UPD: begin
        a_r <= upd;
        x_r <= last_step ? f_r : ram_rdata;
        if (first_step) begin
          f_r <= upd;
        end
        if (last_step) begin
          sum_r <= dec_r ? (sum_r - xxtea_pkg::TEA_DELTA) : (sum_r + xxtea_pkg::TEA_DELTA);
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = ram_rdata;
  assign out_last_word   = out_last_r;

  `XXT_ASSERT_NEXT(a_last_ends_block, out_valid && out_last_word, !out_valid, "result after last word")
  `XXT_ASSERT_NOW(a_pos_in_block, state_r == xxtea_pkg::ST_UPD, {1'b0, pos_r} < n_r, "update outside block")
  `XXT_ASSERT_NOW(a_count_cleared, busy, loaded_cnt_r == '0, "load count not cleared while busy")
  `XXT_ASSERT_NEXT(a_out_follows_read, state_r == xxtea_pkg::ST_OUT, out_valid, "missing result strobe")

endmodule

`default_nettype wire

// ----- sv/xxtea_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module xxtea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
